// File: design/cpig_pkg.sv
`timescale 1ns / 1ps

package cpig_pkg;

    // Configuration register indices.
    localparam logic [2:0] REG_IMAGE_ROWS        = 3'd0;
    localparam logic [2:0] REG_IMAGE_COLS        = 3'd1;
    localparam logic [2:0] REG_KERNEL_ROWS       = 3'd2;
    localparam logic [2:0] REG_KERNEL_COLS       = 3'd3;
    localparam logic [2:0] REG_VERTICAL_STRIDE   = 3'd4;
    localparam logic [2:0] REG_HORIZONTAL_STRIDE = 3'd5;

    localparam int DIM_W   = 13;
    localparam int KER_W   = 4;
    localparam int PATCH_W = 12;
    localparam int IDX_W   = 24;
    localparam int POS_W   = 6;
    localparam int KCNT_W  = 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Clamped geometry as used by the datapath.
    typedef struct packed {
        logic [DIM_W-1:0] ir;
        logic [DIM_W-1:0] ic;
        logic [KER_W-1:0] kr;
        logic [KER_W-1:0] kc;
        logic [DIM_W-1:0] vs;
        logic [DIM_W-1:0] hs;
    } t_geom;

    // One classified patch waiting for the back end.
    typedef struct packed {
        logic [IDX_W-1:0] base;
        logic             ok;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: design/cpig_front.sv
`timescale 1ns / 1ps

module cpig_front import cpig_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_geom              i_geom,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PATCH_W-1:0] i_patch_row,
    input  logic [PATCH_W-1:0] i_patch_col,
    input  t_q_stat            i_q_stat,
    output logic               o_push,
    output t_q_entry           o_entry
);

    localparam int PROD_W = PATCH_W + DIM_W;

    logic              r_v1;
    logic              r_v2;
    logic [PROD_W-1:0] r_row0;
    logic [PROD_W-1:0] r_col0;
    logic [IDX_W-1:0]  r_prod;
    logic [IDX_W-1:0]  r_col0_lo;
    logic              r_ok;

    logic              w_adv2;
    logic              w_ready1;
    logic              n_ok;
    logic [IDX_W-1:0]  n_prod;

    assign w_adv2   = !r_v2 || !i_q_stat.full;
    assign w_ready1 = !r_v1 || w_adv2;
    assign o_ready  = w_ready1;
    assign o_push   = r_v2 && !i_q_stat.full;

    // The patch fits when its far edge stays within the image on both axes.
    assign n_ok = ((PROD_W + 1)'(r_row0) + (PROD_W + 1)'(i_geom.kr) <= (PROD_W + 1)'(i_geom.ir))
               && ((PROD_W + 1)'(r_col0) + (PROD_W + 1)'(i_geom.kc) <= (PROD_W + 1)'(i_geom.ic));
    assign n_prod = r_row0[IDX_W-1:0] * IDX_W'(i_geom.ic);

    assign o_entry.base = r_ok ? (r_prod + r_col0_lo) : '0;
    assign o_entry.ok   = r_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_ready1) begin
                r_v1 <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1 && i_valid) begin
            r_row0 <= PROD_W'(i_patch_row * i_geom.vs);
            r_col0 <= PROD_W'(i_patch_col * i_geom.hs);
        end
        if (w_adv2 && r_v1) begin
            r_prod    <= n_prod;
            r_col0_lo <= r_col0[IDX_W-1:0];
            r_ok      <= n_ok;
        end
    end

endmodule

// File: design/cpig_queue.sv
`timescale 1ns / 1ps

module cpig_queue import cpig_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    input  logic     i_pop,
    output t_q_entry o_head,
    output t_q_stat  o_stat
);

    t_q_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_AW:0]     r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// File: design/cpig_back.sv
`timescale 1ns / 1ps

module cpig_back import cpig_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_geom            i_geom,
    input  t_q_stat          i_q_stat,
    input  t_q_entry         i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [IDX_W-1:0] o_element_index,
    output logic [POS_W-1:0] o_kernel_position,
    output logic             o_patch_valid,
    output logic             o_last
);

    logic              r_act;
    logic              r_ok;
    logic [KCNT_W-1:0] r_row;
    logic [KCNT_W-1:0] r_col;
    logic [POS_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_row_base;

    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_idx;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_ok;
    logic              r_out_last;

    logic              w_out_free;
    logic              w_emit;
    logic              w_row_end;
    logic              w_col_end;
    logic              w_elem_last;

    assign w_out_free  = !r_out_valid || i_ready;
    assign w_emit      = r_act && w_out_free;
    assign w_row_end   = (KER_W'(r_row) == i_geom.kr - KER_W'(1));
    assign w_col_end   = (KER_W'(r_col) == i_geom.kc - KER_W'(1));
    assign w_elem_last = !r_ok || (w_row_end && w_col_end);
    assign o_pop       = !i_q_stat.empty && (!r_act || (w_emit && w_elem_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
            end else if (w_emit && w_elem_last) begin
                r_act <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ok       <= i_head.ok;
            r_row_base <= i_head.base;
            r_row      <= '0;
            r_col      <= '0;
            r_pos      <= '0;
        end else if (w_emit) begin
            r_pos <= r_pos + 1'b1;
            if (w_col_end) begin
                r_col      <= '0;
                r_row      <= r_row + 1'b1;
                r_row_base <= r_row_base + IDX_W'(i_geom.ic);
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (w_emit) begin
            r_out_idx  <= r_ok ? (r_row_base + IDX_W'(r_col)) : '0;
            r_out_pos  <= r_ok ? r_pos : '0;
            r_out_ok   <= r_ok;
            r_out_last <= w_elem_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_element_index   = r_out_idx;
    assign o_kernel_position = r_out_pos;
    assign o_patch_valid     = r_out_ok;
    assign o_last            = r_out_last;

endmodule

// File: design/conv_patch_index_generator_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// s_axis    in         tdata: patch_row [11:0], patch_col [23:12]
// m_axis    out        tdata: element_index [23:0], kernel_position [29:24];
//                      tuser: patch_valid; tlast: last
// cfg       in         i_cfg_index selects the register, i_cfg_data carries the value
//
// A patch that fits the image produces kernel_rows * kernel_cols beats, one per cycle while
// the output is not held; a patch that does not fit produces a single beat. The back end's
// element counter sets this rate. After acceptance a request passes both front-end stages
// and the queue before the back end loads its first beat into the output register.
// Reset is synchronous and active low; it empties the pipeline and queue and sets every
// configuration register to one. Either side may stall independently: the queue absorbs
// classified requests while the output is held, and the output register holds its beat.

module conv_patch_index_generator_top import cpig_pkg::*; #(
    parameter int MAX_DIM    = 4096,
    parameter int MAX_KERNEL = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // patch_row [11:0], patch_col [23:12]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // element_index [23:0], kernel_position [29:24], zeros
    output logic        m_axis_tuser,   // patch_valid
    output logic        m_axis_tlast,
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    // Raw configuration registers, as written.
    logic [DIM_W-1:0] r_image_rows;
    logic [DIM_W-1:0] r_image_cols;
    logic [KER_W-1:0] r_kernel_rows;
    logic [KER_W-1:0] r_kernel_cols;
    logic [DIM_W-1:0] r_vstride;
    logic [DIM_W-1:0] r_hstride;

    t_geom            w_geom;
    t_q_stat          w_q_stat;
    t_q_entry         w_push_entry;
    t_q_entry         w_head;
    logic             w_push;
    logic             w_pop;
    logic [IDX_W-1:0] w_element_index;
    logic [POS_W-1:0] w_kernel_position;
    logic [POS_W-1:0] w_total_m1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_rows  <= DIM_W'(1);
            r_image_cols  <= DIM_W'(1);
            r_kernel_rows <= KER_W'(1);
            r_kernel_cols <= KER_W'(1);
            r_vstride     <= DIM_W'(1);
            r_hstride     <= DIM_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_ROWS:        r_image_rows  <= i_cfg_data;
                REG_IMAGE_COLS:        r_image_cols  <= i_cfg_data;
                REG_KERNEL_ROWS:       r_kernel_rows <= i_cfg_data[KER_W-1:0];
                REG_KERNEL_COLS:       r_kernel_cols <= i_cfg_data[KER_W-1:0];
                REG_VERTICAL_STRIDE:   r_vstride     <= i_cfg_data;
                REG_HORIZONTAL_STRIDE: r_hstride     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp the geometry: kernel sizes to 1..MAX_KERNEL, image sizes to at most MAX_DIM.
    // An image clamp can only take effect when MAX_DIM is below the register's range,
    // so the narrowing of MAX_DIM happens only where it fits.
    always_comb begin
        w_geom.vs = r_vstride;
        w_geom.hs = r_hstride;
        w_geom.ir = (32'(r_image_rows) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_image_rows;
        w_geom.ic = (32'(r_image_cols) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_image_cols;
        if (r_kernel_rows == '0) begin
            w_geom.kr = KER_W'(1);
        end else if (32'(r_kernel_rows) > MAX_KERNEL) begin
            w_geom.kr = KER_W'(MAX_KERNEL);
        end else begin
            w_geom.kr = r_kernel_rows;
        end
        if (r_kernel_cols == '0) begin
            w_geom.kc = KER_W'(1);
        end else if (32'(r_kernel_cols) > MAX_KERNEL) begin
            w_geom.kc = KER_W'(MAX_KERNEL);
        end else begin
            w_geom.kc = r_kernel_cols;
        end
    end

    // Front end: two stages work out the patch origin, check it against the image and
    // form the flat index of the patch's top-left element.
    cpig_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (w_geom),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_patch_row (s_axis_tdata[11:0]),
        .i_patch_col (s_axis_tdata[23:12]),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    // Short queue of classified patches between the two halves.
    cpig_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // Back end: walks the kernel row by row into an output register, one beat per cycle unless held.
    cpig_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_geom            (w_geom),
        .i_q_stat          (w_q_stat),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_element_index   (w_element_index),
        .o_kernel_position (w_kernel_position),
        .o_patch_valid     (m_axis_tuser),
        .o_last            (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_kernel_position, w_element_index};

    assign w_total_m1 = POS_W'(8'(w_geom.kr * w_geom.kc) - 8'd1);

    // An out-of-image patch gives a single, zeroed, final beat.
    a_invalid_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("invalid patch beat is not a zeroed final beat");

    // The final beat of a fitting patch sits at the last kernel position.
    a_last_position : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser && m_axis_tlast |-> w_kernel_position == w_total_m1)
        else $error("final beat at wrong kernel position");

    // The queue is never both full and empty, and is never pushed when full.
    a_queue_sane : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty) && !(w_push && w_q_stat.full))
        else $error("queue status inconsistent");

    // Nothing is taken from an empty queue.
    a_no_empty_pop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

endmodule

// File: test/tb_conv_patch_index_generator_top.sv
`timescale 1ns / 1ps

module tb_conv_patch_index_generator_top;
    import cpig_pkg::*;

    // Register indices that the block does not decode; writes to them must be ignored.
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    localparam int KERNEL_MAX = 8;
    localparam int DIM_MAX    = 4096;
    localparam int STEP_MAX   = 4095;

    // The slowest correct run is roughly 260 requests of 64 beats each with a stalling
    // receiver, so this limit is very generous.
    localparam int CYCLE_LIMIT = 1000000;
    // Length of the long receiver hold-off. It is far longer than the queue and pipeline
    // can absorb, so the request side must back up.
    localparam int HOLD_CYCLES = 500;

    // One expected result beat.
    typedef struct packed {
        logic [IDX_W-1:0] elem_index;
        logic [POS_W-1:0] kpos;
        logic             ok;
        logic             last_flag;
    } t_index_beat;

    // Scoreboard. It keeps its own copy of the six geometry registers, expands each
    // accepted request into the run of image indices it must produce, and compares the
    // result beats in order.
    class patch_index_scoreboard;
        logic [DIM_W-1:0] image_rows, image_cols, v_stride, h_stride;
        logic [KER_W-1:0] kernel_rows, kernel_cols;
        t_index_beat      beats_due[$];
        int               failures, requests, outside, beats_seen;

        function new();
            image_rows  = 1;
            image_cols  = 1;
            kernel_rows = 1;
            kernel_cols = 1;
            v_stride    = 1;
            h_stride    = 1;
        endfunction

        function longint unsigned clip(longint unsigned v, longint unsigned lo,
                                       longint unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [2:0] idx, logic [DIM_W-1:0] data);
            case (idx)
                REG_IMAGE_ROWS:        image_rows  = data;
                REG_IMAGE_COLS:        image_cols  = data;
                REG_KERNEL_ROWS:       kernel_rows = data[KER_W-1:0];
                REG_KERNEL_COLS:       kernel_cols = data[KER_W-1:0];
                REG_VERTICAL_STRIDE:   v_stride    = data;
                REG_HORIZONTAL_STRIDE: h_stride    = data;
                default: ;
            endcase
        endfunction

        // Largest step position whose patch still fits along one axis, or -1 if none fits.
        function int max_step(bit vertical);
            longint unsigned ext, k, s, lim;
            ext = vertical ? clip(image_rows, 0, DIM_MAX) : clip(image_cols, 0, DIM_MAX);
            k   = vertical ? clip(kernel_rows, 1, KERNEL_MAX)
                           : clip(kernel_cols, 1, KERNEL_MAX);
            s   = vertical ? v_stride : h_stride;
            if (ext < k) return -1;
            if (s == 0) return STEP_MAX;
            lim = (ext - k) / s;
            return (lim > STEP_MAX) ? STEP_MAX : int'(lim);
        endfunction

        function void note_request(logic [PATCH_W-1:0] prow, logic [PATCH_W-1:0] pcol);
            longint unsigned kr, kc, ir, ic, row0, col0, idx;
            int          n;
            t_index_beat b;
            kr   = clip(kernel_rows, 1, KERNEL_MAX);
            kc   = clip(kernel_cols, 1, KERNEL_MAX);
            ir   = clip(image_rows, 0, DIM_MAX);
            ic   = clip(image_cols, 0, DIM_MAX);
            row0 = longint'(prow) * v_stride;
            col0 = longint'(pcol) * h_stride;
            requests++;
            if (row0 + kr > ir || col0 + kc > ic) begin
                // The patch leaves the image: a single flagged beat with zeroed fields.
                outside++;
                b = '{elem_index: '0, kpos: '0, ok: 1'b0, last_flag: 1'b1};
                beats_due.push_back(b);
                return;
            end
            n = 0;
            for (longint unsigned r = 0; r < kr; r++) begin
                for (longint unsigned c = 0; c < kc; c++) begin
                    idx          = (row0 + r) * ic + col0 + c;
                    b.elem_index = idx[IDX_W-1:0];
                    b.kpos       = POS_W'(r * kc + c);
                    b.ok         = 1'b1;
                    n++;
                    b.last_flag  = (n == kr * kc);
                    beats_due.push_back(b);
                end
            end
        endfunction

        function void check_beat(logic [31:0] data, logic user, logic lastb);
            t_index_beat want;
            beats_seen++;
            if (beats_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result beat with nothing outstanding: data %h user %b last %b",
                             $realtime, data, user, lastb);
                return;
            end
            want = beats_due.pop_front();
            if (data[IDX_W-1:0] !== want.elem_index || data[29:24] !== want.kpos ||
                data[31:30] !== 2'b00 || user !== want.ok || lastb !== want.last_flag) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0t: mismatch: expected index %0d pos %0d valid %b last %b,",
                             $realtime, want.elem_index, want.kpos, want.ok, want.last_flag);
                    $display("    got index %0d pos %0d pad %b valid %b last %b",
                             data[IDX_W-1:0], data[29:24], data[31:30], user, lastb);
                end
            end
        endfunction

        function int pending();
            return beats_due.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = '0;
    logic [12:0] i_cfg_data    = '0;

    patch_index_scoreboard patch_sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int cycle_count    = 0;
    int settings_used  = 1;

    conv_patch_index_generator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // A hung block or a lost beat ends the run here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // Result side. tready changes only on the falling edge. A requested hold-off is
    // counted down here on the falling edges, while the request side keeps offering patches.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Every result beat is taken at the rising edge on which it is handed over.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            patch_sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Offer one patch request, with random idle cycles in front of it. tvalid stays high
    // between back-to-back requests, so no falling edge both lowers and raises it.
    task automatic offer_patch(input logic [PATCH_W-1:0] prow, input logic [PATCH_W-1:0] pcol);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pcol, prow};
        do @(posedge i_clk); while (!s_axis_tready);
        patch_sb.note_request(prow, pcol);
    endtask

    // Stop offering requests and let every outstanding beat drain. A short extra wait
    // follows once nothing is outstanding.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (patch_sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        patch_sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Write the whole geometry. The block is idle by the time the first write goes out.
    task automatic program_geometry(input logic [12:0] ir, input logic [12:0] ic,
                                    input logic [12:0] kr, input logic [12:0] kc,
                                    input logic [12:0] vs, input logic [12:0] hs);
        drain_results();
        write_reg(REG_IMAGE_ROWS, ir);
        write_reg(REG_IMAGE_COLS, ic);
        write_reg(REG_KERNEL_ROWS, kr);
        write_reg(REG_KERNEL_COLS, kc);
        write_reg(REG_VERTICAL_STRIDE, vs);
        write_reg(REG_HORIZONTAL_STRIDE, hs);
        settings_used++;
    endtask

    // Mostly small images so that the patches land inside; now and then the full size or
    // a value beyond it.
    function automatic logic [12:0] pick_extent();
        case ($urandom_range(0, 9))
            0:       return 13'($urandom_range(0, 8191));
            1:       return 13'(DIM_MAX);
            default: return 13'($urandom_range(1, 48));
        endcase
    endfunction

    // Kernel sizes are mostly legal; sometimes zero or above the maximum, to exercise clamping.
    function automatic logic [12:0] pick_kernel();
        if ($urandom_range(0, 7) == 0)
            return 13'($urandom_range(0, 8191));
        return 13'($urandom_range(1, KERNEL_MAX));
    endfunction

    function automatic logic [12:0] pick_stride();
        case ($urandom_range(0, 7))
            0:       return 13'($urandom_range(0, 8191));
            1:       return 13'd0;
            default: return 13'($urandom_range(1, 4));
        endcase
    endfunction

    // Most requests are placed where the patch fits, so that full index runs come out;
    // the rest are drawn from the whole field range and mostly fall outside the image.
    task automatic random_request();
        int            max_r, max_c;
        logic [PATCH_W-1:0] prow, pcol;
        max_r = patch_sb.max_step(1'b1);
        max_c = patch_sb.max_step(1'b0);
        if ($urandom_range(0, 99) < 85 && max_r >= 0 && max_c >= 0) begin
            prow = PATCH_W'($urandom_range(0, max_r));
            pcol = PATCH_W'($urandom_range(0, max_c));
        end else begin
            prow = PATCH_W'($urandom_range(0, STEP_MAX));
            pcol = PATCH_W'($urandom_range(0, STEP_MAX));
        end
        offer_patch(prow, pcol);
    endtask

    initial begin : stimulus
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry is a 1x1 image and kernel: only the origin fits.
        offer_patch(12'd0, 12'd0);
        offer_patch(12'd1, 12'd0);
        offer_patch(12'd0, 12'd1);
        offer_patch(12'd4095, 12'd4095);

        // Non-square kernel with unequal strides: the last fitting patch on each axis and
        // the first one past it.
        program_geometry(13'd16, 13'd16, 13'd3, 13'd5, 13'd2, 13'd3);
        offer_patch(12'd0, 12'd0);
        offer_patch(12'd6, 12'd3);
        offer_patch(12'd7, 12'd0);
        offer_patch(12'd0, 12'd4);

        // Oversized image and kernel values are clamped; zero vertical stride maps every
        // patch row onto the top of the image.
        program_geometry(13'd8191, 13'd8191, 13'd15, 13'd0, 13'd0, 13'd8191);
        offer_patch(12'd4095, 12'd0);
        offer_patch(12'd0, 12'd1);
        offer_patch(12'd2048, 12'd0);

        // Full image with an 8x8 kernel: the bottom-right patch reaches the largest index.
        program_geometry(13'd4096, 13'd4096, 13'd8, 13'd8, 13'd511, 13'd511);
        offer_patch(12'd8, 12'd8);
        offer_patch(12'd8, 12'd9);
        offer_patch(12'd0, 12'd0);
        offer_patch(12'd4095, 12'd4095);

        // An image with no rows rejects everything.
        program_geometry(13'd0, 13'd5, 13'd1, 13'd1, 13'd1, 13'd1);
        offer_patch(12'd0, 12'd0);

        // Writes to undecoded indices must leave the geometry alone. Then the kernel is
        // made taller than the image, and finally a column-shaped kernel that fits.
        drain_results();
        write_reg(REG_SPARE_6, 13'h1555);
        write_reg(REG_SPARE_7, 13'h0aaa);
        write_reg(REG_IMAGE_ROWS, 13'd4);
        write_reg(REG_KERNEL_ROWS, 13'd8);
        settings_used++;
        offer_patch(12'd0, 12'd0);
        drain_results();
        write_reg(REG_KERNEL_ROWS, 13'd4);
        settings_used++;
        offer_patch(12'd0, 12'd4);

        // Random part. The idling pattern cycles through: none, sender idle, receiver
        // stalling, then both together.
        for (int ph = 0; ph < 8; ph++) begin
            program_geometry(pick_extent(), pick_extent(), pick_kernel(), pick_kernel(),
                             pick_stride(), pick_stride());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            // Once, with the sender running flat out, the receiver holds off long enough
            // for the queue to fill and the request side to be back-pressured.
            if (ph == 4)
                hold_request = 1'b1;
            for (int n = 0; n < 30; n++)
                random_request();
        end

        drain_results();
        $display("Run covered %0d patch requests (%0d outside the image) over %0d geometries.",
                 patch_sb.requests, patch_sb.outside, settings_used);
        $display("%0d result beats compared, %0d mismatches, %0d beats still outstanding.",
                 patch_sb.beats_seen, patch_sb.failures, patch_sb.pending());
        if (patch_sb.failures == 0 && patch_sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
